// File: hdl/srp_pkg.sv
// shared types and constants for the socks5 request parser
package srp_pkg;

  localparam int BYTE_BITS = 8;

  // parser phases
  localparam logic [2:0] PH_VERSION  = 3'd0;
  localparam logic [2:0] PH_COMMAND  = 3'd1;
  localparam logic [2:0] PH_RESERVED = 3'd2;
  localparam logic [2:0] PH_TYPE     = 3'd3;
  localparam logic [2:0] PH_ADDRESS  = 3'd4;
  localparam logic [2:0] PH_PORT     = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;
  localparam logic [2:0] PH_ERROR    = 3'd7;

  // address kinds as reported
  localparam logic [1:0] KIND_IPV4   = 2'd0;
  localparam logic [1:0] KIND_DOMAIN = 2'd1;
  localparam logic [1:0] KIND_IPV6   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_GENERAL  = 2'd0;
  localparam logic [1:0] ERR_COMMAND  = 2'd1;
  localparam logic [1:0] ERR_ADDRTYPE = 2'd2;

  // parse status codes
  localparam logic [1:0] STAT_BUSY  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_ERROR = 2'd2;

  // protocol bytes
  localparam logic [7:0] PROTO_VERSION = 8'd5;
  localparam logic [7:0] CMD_CONNECT   = 8'd1;
  localparam logic [7:0] ATYP_IPV4     = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
  localparam logic [7:0] ATYP_IPV6     = 8'd4;

  localparam logic [7:0] IPV4_BYTES = 8'd4;
  localparam logic [7:0] IPV6_BYTES = 8'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } srp_in_t;

  typedef struct packed {
    logic        consumed;
    logic [1:0]  parse_status;
    logic [1:0]  error_kind;
    logic        addr_valid;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_offset;
    logic [1:0]  address_type;
    logic [7:0]  domain_length;
    logic [15:0] target_port;
    logic [31:0] ipv4_address;
  } srp_out_t;

endpackage

// File: hdl/srp_core.sv
// phase machine and field assembly of the request parser
module srp_core import srp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  srp_in_t  item,
  output srp_out_t res
);

  logic [2:0]  phase_r, phase_nxt, cur_phase;
  logic [1:0]  error_code_r, error_code_nxt, cur_error_code;
  logic [1:0]  addr_kind_r, addr_kind_nxt, cur_addr_kind;
  logic [7:0]  byte_counter_r, byte_counter_nxt, cur_byte_counter;
  logic [7:0]  name_length_r, name_length_nxt, cur_name_length;
  logic [15:0] port_value_r, port_value_nxt, cur_port_value;
  logic [31:0] ipv4_value_r, ipv4_value_nxt, cur_ipv4_value;
  logic [7:0]  b;
  logic [7:0]  cnt_inc;
  logic [7:0]  addr_total;
  logic        consumed;
  logic        avalid;
  logic [7:0]  abyte;
  logic [7:0]  aoff;
  logic [1:0]  status;

  assign b = item.data_byte;

  always_comb begin
    if (item.start_req) begin
      cur_phase        = PH_VERSION;
      cur_error_code   = ERR_GENERAL;
      cur_addr_kind    = KIND_IPV4;
      cur_byte_counter = '0;
      cur_name_length  = '0;
      cur_port_value   = '0;
      cur_ipv4_value   = '0;
    end else begin
      cur_phase        = phase_r;
      cur_error_code   = error_code_r;
      cur_addr_kind    = addr_kind_r;
      cur_byte_counter = byte_counter_r;
      cur_name_length  = name_length_r;
      cur_port_value   = port_value_r;
      cur_ipv4_value   = ipv4_value_r;
    end
  end

  assign cnt_inc    = cur_byte_counter + 8'd1;
  assign addr_total = (cur_addr_kind == KIND_IPV4) ? IPV4_BYTES : IPV6_BYTES;

  always_comb begin
    phase_nxt        = cur_phase;
    error_code_nxt   = cur_error_code;
    addr_kind_nxt    = cur_addr_kind;
    byte_counter_nxt = cur_byte_counter;
    name_length_nxt  = cur_name_length;
    port_value_nxt   = cur_port_value;
    ipv4_value_nxt   = cur_ipv4_value;
    consumed         = 1'b0;
    avalid           = 1'b0;
    abyte            = '0;
    aoff             = '0;
    if (cur_phase != PH_DONE && cur_phase != PH_ERROR) begin
      consumed = 1'b1;
      case (cur_phase)
        PH_VERSION: begin
          phase_nxt = (b == PROTO_VERSION) ? PH_COMMAND : PH_ERROR;
        end
        PH_COMMAND: begin
          if (b == CMD_CONNECT) begin
            phase_nxt = PH_RESERVED;
          end else begin
            error_code_nxt = ERR_COMMAND;
            phase_nxt      = PH_ERROR;
          end
        end
        PH_RESERVED: begin
          phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          byte_counter_nxt = '0;
          if (b inside {ATYP_IPV4, ATYP_DOMAIN, ATYP_IPV6}) begin
            addr_kind_nxt  = (b == ATYP_IPV4)   ? KIND_IPV4 :
                             (b == ATYP_DOMAIN) ? KIND_DOMAIN : KIND_IPV6;
            ipv4_value_nxt = '0;
            phase_nxt      = PH_ADDRESS;
          end else begin
            error_code_nxt = ERR_ADDRTYPE;
            phase_nxt      = PH_ERROR;
          end
        end
        PH_ADDRESS: begin
          if (cur_addr_kind == KIND_DOMAIN) begin
            if (cur_byte_counter == 8'd0) begin
              name_length_nxt = b;
              // empty name skips straight to the port
              if (b == 8'd0) begin
                phase_nxt = PH_PORT;
              end else begin
                byte_counter_nxt = 8'd1;
              end
            end else begin
              avalid = 1'b1;
              abyte  = b;
              aoff   = cur_byte_counter - 8'd1;
              if (cur_byte_counter >= cur_name_length) begin
                byte_counter_nxt = '0;
                phase_nxt        = PH_PORT;
              end else begin
                byte_counter_nxt = cnt_inc;
              end
            end
          end else begin
            avalid = 1'b1;
            abyte  = b;
            aoff   = cur_byte_counter;
            if (cur_addr_kind == KIND_IPV4) begin
              ipv4_value_nxt = {cur_ipv4_value[31-BYTE_BITS:0], b};
            end
            if (cnt_inc >= addr_total) begin
              byte_counter_nxt = '0;
              phase_nxt        = PH_PORT;
            end else begin
              byte_counter_nxt = cnt_inc;
            end
          end
        end
        PH_PORT: begin
          if (cur_byte_counter == 8'd0) begin
            port_value_nxt   = {b, 8'd0};
            byte_counter_nxt = 8'd1;
          end else begin
            port_value_nxt   = {cur_port_value[15:8], b};
            byte_counter_nxt = '0;
            phase_nxt        = PH_DONE;
          end
        end
        default: begin
          phase_nxt = cur_phase;
        end
      endcase
    end
  end

  always_comb begin
    if (phase_nxt == PH_DONE) begin
      status = STAT_DONE;
    end else if (phase_nxt == PH_ERROR) begin
      status = STAT_ERROR;
    end else begin
      status = STAT_BUSY;
    end
  end

  always_comb begin
    res.consumed      = consumed;
    res.parse_status  = status;
    res.error_kind    = error_code_nxt;
    res.addr_valid    = avalid;
    res.addr_byte     = abyte;
    res.addr_offset   = aoff;
    res.address_type  = addr_kind_nxt;
    res.domain_length = name_length_nxt;
    res.target_port   = port_value_nxt;
    res.ipv4_address  = ipv4_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_VERSION;
      error_code_r   <= ERR_GENERAL;
      addr_kind_r    <= KIND_IPV4;
      byte_counter_r <= '0;
      name_length_r  <= '0;
      port_value_r   <= '0;
      ipv4_value_r   <= '0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      error_code_r   <= error_code_nxt;
      addr_kind_r    <= addr_kind_nxt;
      byte_counter_r <= byte_counter_nxt;
      name_length_r  <= name_length_nxt;
      port_value_r   <= port_value_nxt;
      ipv4_value_r   <= ipv4_value_nxt;
    end
  end

endmodule

// File: hdl/socks5_request_parser_unit.sv
// top level of the socks5 request parser
// Takes one request byte per transfer and returns one result per byte, one
// byte every clock cycle when neither side stalls. A byte is captured in the
// input register, runs through the phase machine, and its result sits in the
// output register until taken. The rate is set by the phase machine, whose
// state is updated once per byte.
// A byte with start_req set restarts the parser before it is parsed; after a
// complete or failed request further bytes come back with consumed low.
module socks5_request_parser_unit import srp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  srp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output srp_out_t out_data
);

  logic     in_valid_r;
  srp_in_t  in_item_r;
  logic     out_valid_r;
  srp_out_t out_item_r;
  srp_out_t res;
  logic     advance;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
  end

  srp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// File: hdl/srp_checker.sv
// port-level checks for the socks5 request parser
module srp_checker import srp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input srp_out_t out_data
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // address bytes only come from taken bytes while still parsing
  a_addr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.addr_valid |->
      out_data.consumed && out_data.parse_status == STAT_BUSY)
    else $error("address byte outside address phase");

  // an ignored byte only follows a finished request
  a_ignored_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.consumed |-> out_data.parse_status != STAT_BUSY)
    else $error("byte ignored while parsing");

  // no result can appear without an earlier input transfer
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2) || $past(in_stall))
    else $error("result without input transfer");

endmodule

bind socks5_request_parser_unit srp_checker u_srp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
